[rtl/pgr_pkg.sv]
// Shared types and constants of the PCM gain ramp and channel router.
`default_nettype none
package pgr_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 15;
	localparam int MS_W      = 16;
	localparam int MUL_W     = 16;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int DVD_W     = 31;
	localparam int DVS_W     = 16;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

	localparam logic [DVS_W-1:0] FULL_SCALE = 16'd32767;

	typedef enum logic [1:0] {
		REQ_FRAME = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_RAMP  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MODE_STEREO = 2'd0,
		MODE_LEFT   = 2'd1,
		MODE_RIGHT  = 2'd2,
		MODE_SPARE  = 2'd3
	} mode_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_TMUL  = 8'b0000_0010,
		ST_TDIV  = 8'b0000_0100,
		ST_FMULL = 8'b0000_1000,
		ST_FDIVL = 8'b0001_0000,
		ST_FMULR = 8'b0010_0000,
		ST_FDIVR = 8'b0100_0000,
		ST_FOUT  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic             en;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              vld;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

[rtl/pgr_mul.sv]
// Shared unsigned multiplier with a registered product.
`default_nettype none
module pgr_mul
	import pgr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mul_req_t req,
	output mul_rsp_t      rsp
);

	logic              vld_q;
	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= req.en;
		end
	end

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(req.a) * PROD_W'(req.b);
		end
	end

	assign rsp.vld  = vld_q;
	assign rsp.prod = prod_q;

endmodule
`default_nettype wire

[rtl/pgr_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module pgr_div
	import pgr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W:0]       trial;
	logic                 qbit;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule
`default_nettype wire

[rtl/pcm_gain_ramp_channel_router_top.sv]
// PCM gain ramp and channel router: top level with sequencer and gain state.
//
// Input channel (in_valid/in_ready) carries one request per transfer: an audio
// frame, a one millisecond tick or a gain ramp command. Output channel
// (out_valid/out_ready) carries one result per audio frame only.
// cfg_wr_en/cfg_wr_data write channel_mode; write it only while idle.
//
// One shared 16x16 multiplier forms every product; a restoring divider (one
// quotient bit per cycle) divides by the ramp length, and a shift, add and
// compare divides by 32767.
// Ramp command and unused request: in_ready stays high after the transfer.
// Tick: in_ready stays high when no interpolation is due, else the sequencer
// multiplies in ST_TMUL, then divides in ST_TDIV before the next transfer.
// Frame: states ST_FMULL, ST_FDIVL, ST_FMULR, ST_FDIVR and ST_FOUT follow the
// transfer; in_ready is low while an item is in work.
// A finished frame waits in the sequencer until the output register is free;
// a new input is taken while a result sits in the output register.
// Reset clears gain, ramp state, channel_mode and the output valid.
`default_nettype none
module pcm_gain_ramp_channel_router_top
	import pgr_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 req_type,
	input  wire logic signed [SAMPLE_W-1:0] left_sample,
	input  wire logic signed [SAMPLE_W-1:0] right_sample,
	input  wire logic [GAIN_W-1:0]          ramp_target,
	input  wire logic [MS_W-1:0]            ramp_duration_ms,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      out_left,
	output logic signed [SAMPLE_W-1:0]      out_right,
	output logic [GAIN_W-1:0]               gain_used,
	output logic                            ramp_active,
	input  wire logic                       cfg_wr_en,
	input  wire logic [1:0]                 cfg_wr_data
);

	state_t              state_q;
	mode_t               mode_q;
	logic [GAIN_W-1:0]   gain_now_q;
	logic [GAIN_W-1:0]   gain_from_q;
	logic [GAIN_W-1:0]   gain_goal_q;
	logic [MS_W-1:0]     length_q;
	logic [MS_W-1:0]     elapsed_q;
	logic [SAMPLE_W-1:0] samp_l_q;
	logic [SAMPLE_W-1:0] samp_r_q;
	logic [SAMPLE_W-1:0] res_l_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_left_q;
	logic [SAMPLE_W-1:0] out_right_q;
	logic [GAIN_W-1:0]   gain_used_q;
	logic                ramp_active_q;

	logic                accept;
	req_t                req;
	logic [MS_W-1:0]     elapsed_nxt;
	logic                ramp_up;
	logic [GAIN_W-1:0]   delta_mag;
	logic [SAMPLE_W-1:0] route_l;
	logic [SAMPLE_W-1:0] route_r;
	logic [SAMPLE_W-1:0] abs_l;
	logic [SAMPLE_W-1:0] abs_r;
	logic [SAMPLE_W-1:0] quo_s;
	logic [SAMPLE_W:0]   fs_rem;
	logic [SAMPLE_W-1:0] fs_quo;
	logic [SAMPLE_W-1:0] quo_neg;
	logic                out_free;
	mul_req_t            mul_req;
	mul_rsp_t            mul_rsp;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign req      = req_t'(req_type);
	assign out_free = !out_valid_q || out_ready;

	assign elapsed_nxt = (elapsed_q == {MS_W{1'b1}}) ? elapsed_q : elapsed_q + MS_W'(1);
	assign ramp_up     = (gain_goal_q >= gain_from_q);
	assign delta_mag   = ramp_up ? gain_goal_q - gain_from_q : gain_from_q - gain_goal_q;

	always_comb begin
		case (mode_q)
			MODE_LEFT: begin
				route_l = left_sample;
				route_r = left_sample;
			end
			MODE_RIGHT: begin
				route_l = right_sample;
				route_r = right_sample;
			end
			default: begin
				route_l = left_sample;
				route_r = right_sample;
			end
		endcase
	end

	assign abs_l   = samp_l_q[SAMPLE_W-1] ? ~samp_l_q + SAMPLE_W'(1) : samp_l_q;
	assign abs_r   = samp_r_q[SAMPLE_W-1] ? ~samp_r_q + SAMPLE_W'(1) : samp_r_q;
	assign quo_s   = div_rsp.quotient[SAMPLE_W-1:0];

	// divide by 2^15-1: high part plus a correction of up to two
	assign fs_rem  = {2'b00, mul_rsp.prod[GAIN_W-1:0]} + {1'b0, mul_rsp.prod[DVD_W-1:GAIN_W]};
	assign fs_quo  = mul_rsp.prod[DVD_W-1:GAIN_W]
		+ ((fs_rem >= {FULL_SCALE, 1'b0}) ? SAMPLE_W'(2)
		: (fs_rem >= {1'b0, FULL_SCALE}) ? SAMPLE_W'(1) : SAMPLE_W'(0));
	assign quo_neg = ~fs_quo + SAMPLE_W'(1);

	always_comb begin
		mul_req.en = 1'b0;
		mul_req.a  = '0;
		mul_req.b  = '0;
		case (state_q)
			ST_TMUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_W'(delta_mag);
				mul_req.b  = elapsed_q;
			end
			ST_FMULL: begin
				mul_req.en = 1'b1;
				mul_req.a  = abs_l;
				mul_req.b  = MUL_W'(gain_now_q);
			end
			ST_FMULR: begin
				mul_req.en = 1'b1;
				mul_req.a  = abs_r;
				mul_req.b  = MUL_W'(gain_now_q);
			end
			default: begin
				mul_req.en = 1'b0;
			end
		endcase
	end

	assign div_req.start    = mul_rsp.vld && (state_q == ST_TDIV);
	assign div_req.dividend = mul_rsp.prod[DVD_W-1:0];
	assign div_req.divisor  = length_q;

	pgr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	pgr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_STEREO;
			gain_now_q  <= '0;
			gain_from_q <= '0;
			gain_goal_q <= '0;
			length_q    <= '0;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= mode_t'(cfg_wr_data);
			end
			if (state_q == ST_FOUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req)
							REQ_FRAME: begin
								state_q <= ST_FMULL;
							end
							REQ_TICK: begin
								elapsed_q <= elapsed_nxt;
								if (gain_now_q != gain_goal_q && length_q != '0) begin
									if (elapsed_nxt >= length_q) begin
										gain_now_q <= gain_goal_q;
									end else begin
										state_q <= ST_TMUL;
									end
								end
							end
							REQ_RAMP: begin
								gain_from_q <= gain_now_q;
								gain_goal_q <= ramp_target;
								elapsed_q   <= '0;
								length_q    <= ramp_duration_ms;
								if (ramp_duration_ms == '0) begin
									gain_now_q <= ramp_target;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_TMUL: begin
					state_q <= ST_TDIV;
				end
				ST_TDIV: begin
					if (div_rsp.done) begin
						gain_now_q <= ramp_up ? gain_from_q + quo_s[GAIN_W-1:0]
						                      : gain_from_q - quo_s[GAIN_W-1:0];
						state_q    <= ST_IDLE;
					end
				end
				ST_FMULL: begin
					state_q <= ST_FDIVL;
				end
				ST_FDIVL: begin
					state_q <= ST_FMULR;
				end
				ST_FMULR: begin
					state_q <= ST_FDIVR;
				end
				ST_FDIVR: begin
					state_q <= ST_FOUT;
				end
				ST_FOUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req == REQ_FRAME) begin
			samp_l_q <= route_l;
			samp_r_q <= route_r;
		end
		if (state_q == ST_FDIVL) begin
			res_l_q <= samp_l_q[SAMPLE_W-1] ? quo_neg : fs_quo;
		end
		if (state_q == ST_FDIVR) begin
			samp_r_q <= samp_r_q[SAMPLE_W-1] ? quo_neg : fs_quo;
		end
		if (state_q == ST_FOUT && out_free) begin
			out_left_q    <= res_l_q;
			out_right_q   <= samp_r_q;
			gain_used_q   <= gain_now_q;
			ramp_active_q <= (gain_now_q != gain_goal_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_left    = out_left_q;
	assign out_right   = out_right_q;
	assign gain_used   = gain_used_q;
	assign ramp_active = ramp_active_q;

endmodule
`default_nettype wire

[rtl/pgr_checker.sv]
// Port-level checker of the PCM gain ramp and channel router, with its bind.
`default_nettype none
module pgr_checker
	import pgr_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic [1:0]          req_type,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [SAMPLE_W-1:0] out_left,
	input wire logic [SAMPLE_W-1:0] out_right,
	input wire logic [GAIN_W-1:0]   gain_used,
	input wire logic                ramp_active
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right)
			&& $stable(gain_used) && $stable(ramp_active))
		else $error("output changed while stalled");

	a_frame_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == REQ_FRAME |=> !$rose(out_valid))
		else $error("frame result appeared too early");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && (req_type == REQ_FRAME || req_type == REQ_TICK)))
		else $error("input stalled without a frame or tick transfer");

	a_ramp_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_RAMP || req_type == REQ_NONE) |=> in_ready)
		else $error("ramp command stalled the input");

endmodule

bind pcm_gain_ramp_channel_router_top pgr_checker u_pgr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.req_type    (req_type),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_left    (out_left),
	.out_right   (out_right),
	.gain_used   (gain_used),
	.ramp_active (ramp_active)
);
`default_nettype wire
